// File: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared helpers for concurrent assertions, clocked on clk with rst_n low
// disabling every check.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define TCWRM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication checked in the same cycle.
`define TCWRM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// An implication whose consequent is checked in the next cycle.
`define TCWRM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/tcwrm_pkg.sv
// ---------------------------------------------------------------------------
// tcwrm_pkg
// Widths, reset values and the lane control bundle for the three channel
// window and running mean block.
// ---------------------------------------------------------------------------
package tcwrm_pkg;

    localparam int SAMPLE_W           = 16;
    localparam int MEAN_W             = 16;
    localparam int COUNT_W            = 32;
    // A running total holds up to 2^32-1 samples of 16 bits, plus a sign.
    localparam int RTOT_W             = SAMPLE_W + COUNT_W + 1;
    localparam int CFG_W              = 9;
    localparam int NUM_LANES          = 3;
    localparam int WINDOW_MAX_DEFAULT = 256;

    localparam logic [CFG_W-1:0] WINDOW_LENGTH_RESET = CFG_W'(200);

    // Control from the sequencer, the same for every lane.
    typedef struct packed {
        logic load;       // item accepted: capture sample, read oldest entry
        logic update;     // apply the item to sums and history
        logic drop;       // window full: remove the oldest entry
        logic count_en;   // count not saturated: add to running total
        logic div_start;  // start a division
        logic div_run;    // division is running total over count
    } lane_ctrl_t;

endpackage

// File: rtl/three_channel_window_and_running_mean.sv
// ---------------------------------------------------------------------------
// three_channel_window_and_running_mean
// Sliding window mean and running mean for speed, acceleration and volume,
// one lane per channel with a shared sequencer and a merging output stage.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Payload
//  s_axis    in         tdata[47:0]: speed, acceleration, volume sample
//  m_axis    out        tdata[95:0]: three window means, three running means
//  cfg       in         cfg_wr_data[8:0]: window length, written on cfg_wr_en
//
// An item passes from its accepting edge through the sequencer states: update
// applies it to history and sums, two divisions each follow their start state,
// and the merge loads the result; the next item is accepted only after that.
// A result held on m_axis_tready stalls the item behind it at the merge step,
// and the input with it. Reset is asynchronous, active low; history memories
// are not cleared, as an entry leaves the window only after it was written.
//
`include "assert_macros.svh"

module three_channel_window_and_running_mean
    import tcwrm_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEFAULT
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // Input item: speed_sample [15:0], accel_sample [31:16],
    // volume_sample [47:32].
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [NUM_LANES*SAMPLE_W-1:0]   s_axis_tdata,
    // Result item: speed_window_mean [15:0], accel_window_mean [31:16],
    // volume_window_mean [47:32], speed_running_mean [63:48],
    // accel_running_mean [79:64], volume_running_mean [95:80].
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [2*NUM_LANES*MEAN_W-1:0]   m_axis_tdata,
    // Window length register.
    input  logic                            cfg_wr_en,
    input  logic [CFG_W-1:0]                cfg_wr_data
);

    localparam int PTR_W   = $clog2(WINDOW_MAX);
    localparam int FILL_W  = PTR_W + 1;
    localparam int LEN_W   = (FILL_W > CFG_W) ? FILL_W : CFG_W;
    localparam int ADDR_SW = FILL_W + 1;
    localparam int OUT_W   = 2 * NUM_LANES * MEAN_W;

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UPDATE = 3'd1;
    localparam logic [2:0] S_WSTART = 3'd2;
    localparam logic [2:0] S_WWAIT  = 3'd3;
    localparam logic [2:0] S_RSTART = 3'd4;
    localparam logic [2:0] S_RWAIT  = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    logic [2:0]         state_reg;
    logic [2:0]         state_next;
    logic [CFG_W-1:0]   len_reg;
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;
    logic [PTR_W-1:0]   wp_reg;
    logic [PTR_W-1:0]   wp_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               drop_reg;
    logic               drop_next;
    logic               cnt_en_reg;
    logic               cnt_en_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [OUT_W-1:0]   out_data_reg;

    logic               accept;
    logic               out_load;
    logic [LEN_W-1:0]   len_eff;
    logic [ADDR_SW-1:0] old_sum;
    logic [PTR_W-1:0]   rd_addr;
    lane_ctrl_t         lane_ctrl;
    logic [NUM_LANES-1:0] lane_done;
    logic [MEAN_W-1:0]  win_mean [NUM_LANES];
    logic [MEAN_W-1:0]  run_mean [NUM_LANES];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == S_OUT) && (!out_valid_reg || m_axis_tready);

    // A length of zero acts as one, and one beyond the store as the store.
    always_comb
    begin
        priority if (len_reg == '0)
        begin
            len_eff = LEN_W'(1);
        end
        else if (LEN_W'(len_reg) > LEN_W'(WINDOW_MAX))
        begin
            len_eff = LEN_W'(WINDOW_MAX);
        end
        else
        begin
            len_eff = LEN_W'(len_reg);
        end
    end

    // The oldest entry sits fill places behind the write pointer, modulo
    // the store depth.
    assign old_sum = ADDR_SW'(wp_reg) + ADDR_SW'(WINDOW_MAX) - ADDR_SW'(fill_reg);
    assign rd_addr = (old_sum >= ADDR_SW'(WINDOW_MAX))
                     ? PTR_W'(old_sum - ADDR_SW'(WINDOW_MAX))
                     : PTR_W'(old_sum);

    assign drop_next   = accept ? (LEN_W'(fill_reg) >= len_eff) : drop_reg;
    assign cnt_en_next = accept ? (count_reg != '1) : cnt_en_reg;

    always_comb
    begin
        fill_next  = fill_reg;
        wp_next    = wp_reg;
        count_next = count_reg;
        if (state_reg == S_UPDATE)
        begin
            if (!drop_reg)
            begin
                fill_next = fill_reg + 1'b1;
            end
            wp_next = (wp_reg == PTR_W'(WINDOW_MAX - 1)) ? '0 : wp_reg + 1'b1;
            if (cnt_en_reg)
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    // Sequencer: the lanes run in lock step, so their done flags agree.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE: state_next = S_WSTART;
            S_WSTART: state_next = S_WWAIT;
            S_WWAIT:
            begin
                if (&lane_done)
                begin
                    state_next = S_RSTART;
                end
            end
            S_RSTART: state_next = S_RWAIT;
            S_RWAIT:
            begin
                if (&lane_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        lane_ctrl.load      = accept;
        lane_ctrl.update    = (state_reg == S_UPDATE);
        lane_ctrl.drop      = drop_reg;
        lane_ctrl.count_en  = cnt_en_reg;
        lane_ctrl.div_start = (state_reg == S_WSTART) || (state_reg == S_RSTART);
        lane_ctrl.div_run   = (state_reg == S_RSTART) || (state_reg == S_RWAIT);
    end

    // Output register: a waiting result is replaced only once taken.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            len_reg       <= WINDOW_LENGTH_RESET;
            fill_reg      <= '0;
            wp_reg        <= '0;
            count_reg     <= '0;
            drop_reg      <= 1'b0;
            cnt_en_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_wr_en)
            begin
                len_reg <= cfg_wr_data;
            end
            fill_reg      <= fill_next;
            wp_reg        <= wp_next;
            count_reg     <= count_next;
            drop_reg      <= drop_next;
            cnt_en_reg    <= cnt_en_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Merging stage: gather the six means of the three lanes.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= {run_mean[2], run_mean[1], run_mean[0],
                             win_mean[2], win_mean[1], win_mean[0]};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    tcwrm_lane #(
        .WINDOW_MAX    (WINDOW_MAX),
        .SIGNED_SAMPLE (1'b1)
    ) u_lane_speed (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (lane_ctrl),
        .sample       (s_axis_tdata[SAMPLE_W-1:0]),
        .rd_addr      (rd_addr),
        .wr_addr      (wp_reg),
        .fill         (fill_reg),
        .count        (count_reg),
        .div_done     (lane_done[0]),
        .window_mean  (win_mean[0]),
        .running_mean (run_mean[0])
    );

    tcwrm_lane #(
        .WINDOW_MAX    (WINDOW_MAX),
        .SIGNED_SAMPLE (1'b1)
    ) u_lane_accel (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (lane_ctrl),
        .sample       (s_axis_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .rd_addr      (rd_addr),
        .wr_addr      (wp_reg),
        .fill         (fill_reg),
        .count        (count_reg),
        .div_done     (lane_done[1]),
        .window_mean  (win_mean[1]),
        .running_mean (run_mean[1])
    );

    tcwrm_lane #(
        .WINDOW_MAX    (WINDOW_MAX),
        .SIGNED_SAMPLE (1'b0)
    ) u_lane_volume (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (lane_ctrl),
        .sample       (s_axis_tdata[3*SAMPLE_W-1:2*SAMPLE_W]),
        .rd_addr      (rd_addr),
        .wr_addr      (wp_reg),
        .fill         (fill_reg),
        .count        (count_reg),
        .div_done     (lane_done[2]),
        .window_mean  (win_mean[2]),
        .running_mean (run_mean[2])
    );

    // The lanes must finish their divisions in the same cycle.
    `TCWRM_ASSERT_IMP(a_lanes_in_step, lane_done != '0, lane_done == '1, "lanes out of step")
    // The fill never passes the depth of the history store.
    `TCWRM_ASSERT(a_fill_bound, fill_reg <= FILL_W'(WINDOW_MAX), "window fill beyond store")
    // Means are only ever computed over a non-empty window and count.
    `TCWRM_ASSERT_IMP(a_div_nonzero, state_reg == S_WSTART, (fill_reg != '0) && (count_reg != '0), "division by zero")
    // The sample count never goes backwards.
    `TCWRM_ASSERT_NEXT(a_count_mono, 1'b1, count_reg >= $past(count_reg), "sample count decreased")
    // A result appears only from the merging step.
    `TCWRM_ASSERT_IMP(a_out_source, $rose(out_valid_reg), $past(state_reg == S_OUT), "result without merge")

endmodule

// File: rtl/tcwrm_div.sv
// ---------------------------------------------------------------------------
// tcwrm_div
// Restoring divider: signed dividend by unsigned divisor, one quotient bit
// per cycle, truncating toward zero.
// ---------------------------------------------------------------------------
module tcwrm_div
    import tcwrm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [RTOT_W-1:0] dividend,
    input  logic [COUNT_W-1:0]       divisor,
    output logic                     done,
    output logic [MEAN_W-1:0]        quotient
);

    localparam int STEP_W = $clog2(MEAN_W);

    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [RTOT_W-1:0] rem_reg;
    logic [RTOT_W-1:0] rem_next;
    logic [RTOT_W-1:0] dsh_reg;
    logic [RTOT_W-1:0] dsh_next;
    logic [MEAN_W-1:0] q_reg;
    logic [MEAN_W-1:0] q_next;
    logic              neg_reg;
    logic              neg_next;
    logic              fits;

    // The mean always lies within the sample range, so the magnitude of the
    // quotient fits in MEAN_W bits and MEAN_W steps suffice.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        neg_next  = neg_reg;
        fits      = rem_reg >= dsh_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(MEAN_W - 1);
            neg_next  = dividend[RTOT_W-1];
            rem_next  = dividend[RTOT_W-1] ? RTOT_W'(-dividend) : RTOT_W'(dividend);
            dsh_next  = RTOT_W'(divisor) << (MEAN_W - 1);
            q_next    = '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = rem_reg - dsh_reg;
            end
            q_next   = {q_reg[MEAN_W-2:0], fits};
            dsh_next = dsh_reg >> 1;
            step_next = step_reg - 1'b1;
            if (step_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? MEAN_W'(-q_reg) : q_reg;

endmodule

// File: rtl/tcwrm_lane.sv
// ---------------------------------------------------------------------------
// tcwrm_lane
// One channel: sample history, window sum, running total, and a divider
// that produces the window mean and then the running mean.
// ---------------------------------------------------------------------------
module tcwrm_lane
    import tcwrm_pkg::*;
#(
    parameter int WINDOW_MAX    = WINDOW_MAX_DEFAULT,
    parameter bit SIGNED_SAMPLE = 1'b1
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  lane_ctrl_t                    ctrl,
    input  logic [SAMPLE_W-1:0]           sample,
    input  logic [$clog2(WINDOW_MAX)-1:0] rd_addr,
    input  logic [$clog2(WINDOW_MAX)-1:0] wr_addr,
    input  logic [$clog2(WINDOW_MAX):0]   fill,
    input  logic [COUNT_W-1:0]            count,
    output logic                          div_done,
    output logic [MEAN_W-1:0]             window_mean,
    output logic [MEAN_W-1:0]             running_mean
);

    localparam int PTR_W  = $clog2(WINDOW_MAX);
    localparam int WSUM_W = SAMPLE_W + PTR_W + 1;

    logic [SAMPLE_W-1:0]        hist_mem [WINDOW_MAX];
    logic [SAMPLE_W-1:0]        sample_reg;
    logic [SAMPLE_W-1:0]        old_reg;
    logic signed [WSUM_W-1:0]   wsum_reg;
    logic signed [WSUM_W-1:0]   wsum_next;
    logic signed [RTOT_W-1:0]   rtot_reg;
    logic signed [RTOT_W-1:0]   rtot_next;
    logic signed [WSUM_W-1:0]   smp_w;
    logic signed [WSUM_W-1:0]   old_w;
    logic signed [RTOT_W-1:0]   smp_r;
    logic signed [RTOT_W-1:0]   div_dividend;
    logic [COUNT_W-1:0]         div_divisor;
    logic [MEAN_W-1:0]          div_quotient;
    logic [MEAN_W-1:0]          win_mean_reg;
    logic [MEAN_W-1:0]          run_mean_reg;

    // History store; the oldest entry is read at the accept edge, before the
    // new sample may overwrite the same slot in the following cycle.
    always_ff @(posedge clk)
    begin
        if (ctrl.update)
        begin
            hist_mem[wr_addr] <= sample_reg;
        end
        if (ctrl.load)
        begin
            old_reg    <= hist_mem[rd_addr];
            sample_reg <= sample;
        end
    end

    assign smp_w = {{(WSUM_W - SAMPLE_W){SIGNED_SAMPLE & sample_reg[SAMPLE_W-1]}}, sample_reg};
    assign old_w = {{(WSUM_W - SAMPLE_W){SIGNED_SAMPLE & old_reg[SAMPLE_W-1]}}, old_reg};
    assign smp_r = {{(RTOT_W - SAMPLE_W){SIGNED_SAMPLE & sample_reg[SAMPLE_W-1]}}, sample_reg};

    always_comb
    begin
        wsum_next = wsum_reg;
        rtot_next = rtot_reg;
        if (ctrl.update)
        begin
            wsum_next = ctrl.drop ? (wsum_reg + smp_w - old_w) : (wsum_reg + smp_w);
            if (ctrl.count_en)
            begin
                rtot_next = rtot_reg + smp_r;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wsum_reg <= '0;
            rtot_reg <= '0;
        end
        else
        begin
            wsum_reg <= wsum_next;
            rtot_reg <= rtot_next;
        end
    end

    assign div_dividend = ctrl.div_run ? rtot_reg : RTOT_W'(wsum_reg);
    assign div_divisor  = ctrl.div_run ? count : COUNT_W'(fill);

    tcwrm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctrl.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_ff @(posedge clk)
    begin
        if (div_done)
        begin
            if (ctrl.div_run)
            begin
                run_mean_reg <= div_quotient;
            end
            else
            begin
                win_mean_reg <= div_quotient;
            end
        end
    end

    assign window_mean  = win_mean_reg;
    assign running_mean = run_mean_reg;

endmodule
